FILE: design/vmau_pkg.sv
package vmau_pkg;

  localparam int unsigned Lanes    = 8;
  localparam int unsigned LaneW    = 16;
  localparam int unsigned AccW     = 48;
  localparam int unsigned ProdW    = 2 * (LaneW + 1);
  localparam int unsigned OpW      = 6;
  localparam int unsigned ElemW    = 4;
  localparam int unsigned DestW    = 5;
  localparam int unsigned InDataW  = 272;
  localparam int unsigned OutDataW = 520;

  // product kind, op[2:0]
  localparam logic [2:0] KIND_FRAC  = 3'd0;
  localparam logic [2:0] KIND_LOW   = 3'd4;
  localparam logic [2:0] KIND_MID_S = 3'd5;
  localparam logic [2:0] KIND_MID_U = 3'd6;
  localparam logic [2:0] KIND_HIGH  = 3'd7;

  localparam logic [AccW-1:0] FRAC_ROUND = 48'h0000_0000_8000;

  typedef struct packed {
    logic       ok;
    logic       acc_mode;
    logic [2:0] kind;
  } lane_ctrl_t;

  function automatic lane_ctrl_t decode_op(input logic [OpW-1:0] op);
    lane_ctrl_t c;
    c.kind     = op[2:0];
    c.acc_mode = op[3];
    c.ok       = (op[5:4] == 2'b00) && ((op[2:0] == KIND_FRAC) || op[2]);
    return c;
  endfunction

  // source lane of the second operand for lane i
  function automatic logic [2:0] pick_lane(input logic [ElemW-1:0] e, input logic [2:0] i);
    logic [2:0] sel;
    if (e < 4'd2) begin
      sel = i;
    end else if (e == 4'd2) begin
      sel = {i[2:1], 1'b0};
    end else if (e == 4'd3) begin
      sel = {i[2:1], 1'b1};
    end else if (e < 4'd8) begin
      sel = {i[2], e[1:0]};
    end else begin
      sel = e[2:0];
    end
    return sel;
  endfunction

endpackage

FILE: design/vmau_lane.sv
module vmau_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic                             commit_i,
  input  vmau_pkg::lane_ctrl_t             mul_ctrl_i,
  input  vmau_pkg::lane_ctrl_t             add_ctrl_i,
  input  logic [vmau_pkg::LaneW-1:0]       vs_i,
  input  logic [vmau_pkg::LaneW-1:0]       vt_i,
  output logic [vmau_pkg::LaneW-1:0]       res_o,
  output logic [vmau_pkg::AccW-1:0]        acc_o
);

  logic signed [vmau_pkg::LaneW:0]   mul_a, mul_b;
  logic signed [vmau_pkg::ProdW-1:0] prod_d, prod_q;
  logic [vmau_pkg::AccW-1:0]         acc_d, acc_q;
  logic [vmau_pkg::AccW-1:0]         addend, base, sum;
  logic                              in_range, signed_clamp;
  logic [vmau_pkg::LaneW-1:0]        clamped;

  always_comb begin
    mul_a = {((mul_ctrl_i.kind == vmau_pkg::KIND_LOW) ||
              (mul_ctrl_i.kind == vmau_pkg::KIND_MID_U)) ? 1'b0 : vs_i[15], vs_i};
    mul_b = {((mul_ctrl_i.kind == vmau_pkg::KIND_LOW) ||
              (mul_ctrl_i.kind == vmau_pkg::KIND_MID_S)) ? 1'b0 : vt_i[15], vt_i};
    prod_d = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    unique case (add_ctrl_i.kind)
      vmau_pkg::KIND_FRAC:  addend = {{13{prod_q[33]}}, prod_q, 1'b0};
      vmau_pkg::KIND_LOW:   addend = {32'd0, prod_q[31:16]};
      vmau_pkg::KIND_MID_S,
      vmau_pkg::KIND_MID_U: addend = {{14{prod_q[33]}}, prod_q};
      vmau_pkg::KIND_HIGH:  addend = {prod_q[31:0], 16'd0};
      default:              addend = '0;
    endcase
    if (add_ctrl_i.acc_mode) begin
      base = acc_q;
    end else if (add_ctrl_i.kind == vmau_pkg::KIND_FRAC) begin
      base = vmau_pkg::FRAC_ROUND;
    end else begin
      base = '0;
    end
    sum          = base + addend;
    in_range     = (&sum[47:31]) || (~|sum[47:31]);
    signed_clamp = (add_ctrl_i.kind != vmau_pkg::KIND_LOW) &&
                   (add_ctrl_i.kind != vmau_pkg::KIND_MID_U);
    if (signed_clamp) begin
      clamped = in_range ? sum[31:16] : (sum[47] ? 16'h8000 : 16'h7FFF);
    end else begin
      clamped = in_range ? sum[15:0] : (sum[47] ? 16'h0000 : 16'hFFFF);
    end
    acc_d = add_ctrl_i.ok ? sum : acc_q;
    res_o = add_ctrl_i.ok ? clamped : '0;
    acc_o = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (commit_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

FILE: design/vmau_merge.sv
module vmau_merge (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  commit_i,
  input  logic [vmau_pkg::Lanes-1:0][vmau_pkg::LaneW-1:0]       res_i,
  input  logic [vmau_pkg::Lanes-1:0][vmau_pkg::AccW-1:0]        acc_i,
  input  logic                                                  ok_i,
  input  logic [vmau_pkg::DestW-1:0]                            dest_i,
  output logic                                                  adv_o,
  output logic                                                  m_axis_tvalid_o,
  input  logic                                                  m_axis_tready_i,
  output logic [vmau_pkg::OutDataW-1:0]                         m_axis_tdata_o
);

  logic                                                  valid_d, valid_q;
  logic [vmau_pkg::OutDataW-1:0]                         data_d, data_q;
  logic [vmau_pkg::Lanes-1:0][vmau_pkg::LaneW-1:0]       acc_lo, acc_mid, acc_hi;

  always_comb begin
    for (int i = 0; i < vmau_pkg::Lanes; i++) begin
      acc_lo[i]  = acc_i[i][15:0];
      acc_mid[i] = acc_i[i][31:16];
      acc_hi[i]  = acc_i[i][47:32];
    end
    data_d = {2'b00, acc_hi, acc_mid, acc_lo, dest_i, ok_i, res_i};
  end

  assign adv_o   = !valid_q || m_axis_tready_i;
  assign valid_d = commit_i || (valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i) begin
      data_q <= data_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;

endmodule

FILE: design/vector_multiply_accumulate_unit_core.sv
// Channel   Dir  Width  Contents
// s_axis    in   272    one multiply request
// m_axis    out  520    clamped lanes, op_ok, dest echo, accumulator slices
//
// Two stages: operand shuffle and 17x17 multiply into a product register, then
// accumulate, clamp and load into the output register. One request per cycle while
// m_axis does not stall. An accepted request waits in the product register until the
// output register is free, then m_axis_tvalid_o rises. Reset clears the accumulators
// and all valid bits. A stall on m_axis holds both stages and drops s_axis_tready_o
// only once the product stage is also full.
module vector_multiply_accumulate_unit_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // op[5:0] element[9:6] vs_low[73:10] vs_high[137:74] vt_low[201:138]
  // vt_high[265:202] dest_reg[270:266]
  input  logic [vmau_pkg::InDataW-1:0]      s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // result_low[63:0] result_high[127:64] op_ok[128] dest_reg_out[133:129]
  // acc_low_lanes_0_3[197:134] acc_low_lanes_4_7[261:198]
  // acc_mid_lanes_0_3[325:262] acc_mid_lanes_4_7[389:326]
  // acc_high_lanes_0_3[453:390] acc_high_lanes_4_7[517:454]
  output logic [vmau_pkg::OutDataW-1:0]     m_axis_tdata_o
);

  logic [vmau_pkg::OpW-1:0]                              op;
  logic [vmau_pkg::ElemW-1:0]                            element;
  logic [vmau_pkg::Lanes-1:0][vmau_pkg::LaneW-1:0]       vs, vt_raw, vt;
  logic [vmau_pkg::DestW-1:0]                            dest;
  vmau_pkg::lane_ctrl_t                                  mul_ctrl, add_ctrl_q;
  logic [vmau_pkg::DestW-1:0]                            dest_q;
  logic                                                  s1_valid_q, s1_valid_d;
  logic                                                  load, commit, adv;
  logic [vmau_pkg::Lanes-1:0][vmau_pkg::LaneW-1:0]       res;
  logic [vmau_pkg::Lanes-1:0][vmau_pkg::AccW-1:0]        acc;

  assign op       = s_axis_tdata_i[5:0];
  assign element  = s_axis_tdata_i[9:6];
  assign vs       = s_axis_tdata_i[137:10];
  assign vt_raw   = s_axis_tdata_i[265:138];
  assign dest     = s_axis_tdata_i[270:266];
  assign mul_ctrl = vmau_pkg::decode_op(op);

  always_comb begin
    for (int i = 0; i < vmau_pkg::Lanes; i++) begin
      vt[i] = vt_raw[vmau_pkg::pick_lane(element, 3'(i))];
    end
  end

  assign s_axis_tready_o = !s1_valid_q || adv;
  assign load            = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = s1_valid_q && adv;
  assign s1_valid_d      = load || (s1_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      add_ctrl_q <= mul_ctrl;
      dest_q     <= dest;
    end
  end

  for (genvar g = 0; g < vmau_pkg::Lanes; g++) begin : g_lane
    vmau_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (load),
      .commit_i   (commit),
      .mul_ctrl_i (mul_ctrl),
      .add_ctrl_i (add_ctrl_q),
      .vs_i       (vs[g]),
      .vt_i       (vt[g]),
      .res_o      (res[g]),
      .acc_o      (acc[g])
    );
  end

  vmau_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .commit_i        (commit),
    .res_i           (res),
    .acc_i           (acc),
    .ok_i            (add_ctrl_q.ok),
    .dest_i          (dest_q),
    .adv_o           (adv),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input stalled while output side free");

  a_bad_op_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[128]) |-> (m_axis_tdata_o[127:0] == '0))
    else $error("unknown opcode gave nonzero result");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(dest_q)))
    else $error("product stage lost a request under stall");

  a_commit_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> m_axis_tvalid_o)
    else $error("committed request missing at output");

endmodule
